>>> rtl/core/rtp_pkg.sv
// shared constants and types for the rigid point transform
`timescale 1ns / 1ps

package rtp_pkg;

  // fraction bits of the coordinates and of the coefficients
  localparam int unsigned FracBits = 16;

  // register stages inside one row datapath
  localparam int unsigned RowStages = 5;

  // input register plus the row datapath
  localparam int unsigned PipeDepth = RowStages + 1;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegRotRow0 = 3'd0,
    RegRotRow1 = 3'd1,
    RegRotRow2 = 3'd2,
    RegOffsetX = 3'd3,
    RegOffsetY = 3'd4,
    RegOffsetZ = 3'd5
  } rtp_reg_e;

endpackage

>>> rtl/core/rigid_transform_point.sv
// top level of the rigid point transform: config registers, input stage, three row datapaths
//
// channel   direction  handshake                    payload
// request   in         start high, busy low         in_x_i, in_y_i, in_z_i
// result    out        done_o strobe, one cycle     out_x_o, out_y_o, out_z_o, clipped_o
// config    in         cfg_valid_i and cfg_ready_o  cfg_index_i, cfg_data_i
//
// a new request can be taken every cycle while busy is low; each result passes
// through the input register and the five stages of each row datapath
// reset clears the valid bits and loads the identity matrix and zero offsets
// busy is high only in the first cycle after reset, then the pipeline never stalls
`timescale 1ns / 1ps

module rigid_transform_point
  import rtp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 18,
  localparam int RowW = 3 * COEF_WIDTH,
  localparam int CfgW = (RowW > COORD_WIDTH) ? RowW : COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          clipped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [CfgW-1:0]               cfg_data_i
);

  logic                          rdy_q;
  logic                          accept;
  logic                          cfg_we;
  logic [PipeDepth-1:0]          v_d, v_q;
  logic [RowW-1:0]               rot_q [3];
  logic signed [COORD_WIDTH-1:0] off_q [3];
  logic signed [COORD_WIDTH-1:0] x_q, y_q, z_q;
  logic signed [COORD_WIDTH-1:0] value [3];
  logic [2:0]                    clip;

  assign busy        = !rdy_q;
  assign cfg_ready_o = rdy_q;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign v_d         = {v_q[PipeDepth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q <= 1'b0;
      v_q   <= '0;
    end else begin
      rdy_q <= 1'b1;
      v_q   <= v_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        rot_q[r] <= RowW'(64'd1 << (int'(FracBits) + r * COEF_WIDTH));
        off_q[r] <= '0;
      end
    end else if (cfg_we) begin
      case (rtp_reg_e'(cfg_index_i))
        RegRotRow0: rot_q[0] <= cfg_data_i[RowW-1:0];
        RegRotRow1: rot_q[1] <= cfg_data_i[RowW-1:0];
        RegRotRow2: rot_q[2] <= cfg_data_i[RowW-1:0];
        RegOffsetX: off_q[0] <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        RegOffsetY: off_q[1] <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        RegOffsetZ: off_q[2] <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    x_q <= in_x_i;
    y_q <= in_y_i;
    z_q <= in_z_i;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    rtp_row #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_row (
      .clk_i  (clk_i),
      .row_i  (rot_q[r]),
      .off_i  (off_q[r]),
      .x_i    (x_q),
      .y_i    (y_q),
      .z_i    (z_q),
      .value_o(value[r]),
      .clip_o (clip[r])
    );
  end

  assign done_o    = v_q[PipeDepth-1];
  assign out_x_o   = value[0];
  assign out_y_o   = value[1];
  assign out_z_o   = value[2];
  assign clipped_o = |clip;

`ifndef SYNTHESIS
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("request did not produce a result after the pipeline latency");

  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("result strobe without a matching request");

  a_no_req_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##6 !done_o)
    else $error("result strobe appeared for an idle cycle");
`endif

endmodule

>>> rtl/core/rtp_row.sv
// one output coordinate: dot product with a matrix row, offset, round and saturate
`timescale 1ns / 1ps

module rtp_row
  import rtp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 18
) (
  input  logic                          clk_i,
  input  logic [3*COEF_WIDTH-1:0]       row_i,
  input  logic signed [COORD_WIDTH-1:0] off_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  output logic signed [COORD_WIDTH-1:0] value_o,
  output logic                          clip_o
);

  localparam int LoW  = COORD_WIDTH / 2;
  localparam int HiW  = COORD_WIDTH - LoW;
  localparam int PloW = COEF_WIDTH + LoW + 1;
  localparam int PhiW = COEF_WIDTH + HiW;
  localparam int MagW = (COEF_WIDTH > int'(FracBits)) ? COEF_WIDTH : int'(FracBits);
  localparam int AccW = MagW + COORD_WIDTH + 3;
  localparam int ResW = AccW - int'(FracBits);
  localparam int UpW  = ResW - COORD_WIDTH + 1;
  localparam logic signed [AccW-1:0] RoundC = AccW'(1) <<< (FracBits - 1);
  localparam logic signed [COORD_WIDTH-1:0] MaxV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MinV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0]  pt [3];
  logic signed [COEF_WIDTH-1:0]   coef [3];

  logic signed [COEF_WIDTH+LoW:0]   plo_d [3];
  logic signed [COEF_WIDTH+LoW:0]   plo_q [3];
  logic signed [COEF_WIDTH+HiW-1:0] phi_d [3];
  logic signed [COEF_WIDTH+HiW-1:0] phi_q [3];
  logic signed [AccW-1:0]           prod_d [3];
  logic signed [AccW-1:0]           prod_q [3];
  logic signed [AccW-1:0]           pair_d, pair_q;
  logic signed [AccW-1:0]           rest_d, rest_q;
  logic signed [AccW-1:0]           acc_d, acc_q;
  logic [ResW-1:0]                  res;
  logic [UpW-1:0]                   upper;
  logic                             ovf;
  logic signed [COORD_WIDTH-1:0]    value_d, value_q;
  logic                             clip_d, clip_q;

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  // split each coordinate so that each product takes only a half word of the coordinate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c]   = $signed(row_i[c*COEF_WIDTH +: COEF_WIDTH]);
      plo_d[c]  = PloW'(coef[c]) * PloW'($signed({1'b0, pt[c][LoW-1:0]}));
      phi_d[c]  = PhiW'(coef[c]) * PhiW'($signed(pt[c][COORD_WIDTH-1:LoW]));
      prod_d[c] = (AccW'(phi_q[c]) <<< LoW) + AccW'(plo_q[c]);
    end
  end

  assign pair_d = prod_q[0] + prod_q[1];
  assign rest_d = prod_q[2] + (AccW'(off_i) <<< FracBits) + RoundC;
  assign acc_d  = pair_q + rest_q;

  // round to nearest by the added half, then clamp to the coordinate range
  always_comb begin
    res     = acc_q[AccW-1:FracBits];
    upper   = res[ResW-1:COORD_WIDTH-1];
    ovf     = !((&upper) || !(|upper));
    clip_d  = ovf;
    value_d = ovf ? (res[ResW-1] ? MinV : MaxV) : $signed(res[COORD_WIDTH-1:0]);
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      plo_q[c]  <= plo_d[c];
      phi_q[c]  <= phi_d[c];
      prod_q[c] <= prod_d[c];
    end
    pair_q  <= pair_d;
    rest_q  <= rest_d;
    acc_q   <= acc_d;
    value_q <= value_d;
    clip_q  <= clip_d;
  end

  assign value_o = value_q;
  assign clip_o  = clip_q;

endmodule
